### rtl/aes_pkg.sv
package aes_pkg;

   localparam int BLOCK_WORDS = 4;
   localparam int MAX_KEY_WORDS_DEFAULT = 60;
   localparam int NUM_ROUNDS_MAX = 14;

   localparam logic [2:0] CSR_KEY_MODE = 3'd0;
   localparam logic [2:0] CSR_KEY_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_3 = 3'd4;

   localparam logic [1:0] MODE_AES192 = 2'd1;
   localparam logic [1:0] MODE_AES256 = 2'd2;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] GF_POLY = 8'h1b;

   typedef enum logic {KX_IDLE, KX_RUN} kx_state_type;

   typedef struct packed {
      logic       restart;
      logic [1:0] mode;
   } kx_cmd_type;

   typedef struct packed {
      logic busy;
   } kx_status_type;

   typedef struct packed {
      logic valid;
      logic func;
   } stage_ctl_type;

   localparam logic [2047:0] SBOX_BITS = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_BITS = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_BITS[2047 - 8 * int'(x) -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return INV_SBOX_BITS[2047 - 8 * int'(x) -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [3:0] rounds_of(input logic [1:0] mode);
      logic [3:0] nr;
      case (mode)
         MODE_AES192: nr = 4'd12;
         MODE_AES256: nr = 4'd14;
         default:     nr = 4'd10;
      endcase
      return nr;
   endfunction

   function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      for (int b = 0; b < 16; b++) begin
         o[127 - 8 * b -: 8] = inv ? inv_sbox(s[127 - 8 * b -: 8]) : sbox(s[127 - 8 * b -: 8]);
      end
      return o;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inv) begin
               o[127 - 8 * (((c + r) % 4) * 4 + r) -: 8] = s[127 - 8 * (c * 4 + r) -: 8];
            end else begin
               o[127 - 8 * (c * 4 + r) -: 8] = s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8];
            end
         end
      end
      return o;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
      logic [7:0] a [4];
      logic [7:0] x1 [4];
      logic [7:0] x2 [4];
      logic [7:0] x3 [4];
      logic [7:0] m0 [4];
      logic [7:0] m1 [4];
      logic [7:0] m2 [4];
      logic [7:0] m3 [4];
      logic [31:0] o;
      for (int k = 0; k < 4; k++) begin
         a[k] = col[31 - 8 * k -: 8];
         x1[k] = xtime(a[k]);
         x2[k] = xtime(x1[k]);
         x3[k] = xtime(x2[k]);
         // coefficient sets {2,3,1,1} or {e,b,d,9}
         m0[k] = inv ? (x3[k] ^ x2[k] ^ x1[k]) : x1[k];
         m1[k] = inv ? (x3[k] ^ x1[k] ^ a[k]) : (x1[k] ^ a[k]);
         m2[k] = inv ? (x3[k] ^ x2[k] ^ a[k]) : a[k];
         m3[k] = inv ? (x3[k] ^ a[k]) : a[k];
      end
      for (int r = 0; r < 4; r++) begin
         o[31 - 8 * r -: 8] = m0[r] ^ m1[(r + 1) % 4] ^ m2[(r + 2) % 4] ^ m3[(r + 3) % 4];
      end
      return o;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         o[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32], inv);
      end
      return o;
   endfunction

endpackage

### rtl/aes_key_expand.sv
module aes_key_expand
   import aes_pkg::*;
#(
   parameter int MAX_KEY_WORDS_STORED = MAX_KEY_WORDS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  kx_cmd_type    cmd,
   input  logic [255:0]  key_bits,
   output kx_status_type status,
   output logic [31:0]   round_keys [MAX_KEY_WORDS_STORED]
);

   localparam int IW = $clog2(MAX_KEY_WORDS_STORED);
   localparam logic [6:0] MAX_WORDS = 7'(MAX_KEY_WORDS_STORED);

   kx_state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [2:0]    pos_ff, pos_in;
   logic [7:0]    rc_ff, rc_in;
   logic [31:0]   win_ff [8];
   logic [31:0]   round_key_ff [MAX_KEY_WORDS_STORED];

   logic [31:0] key_word [8];
   logic [3:0]  nk;
   logic [2:0]  nk_last;
   logic [6:0]  full_words;
   logic [IW-1:0] last_idx;
   logic [31:0] t, new_word, back_word;
   logic        we, in_key;

   for (genvar j = 0; j < 8; j++) begin : g_kw
      assign key_word[j] = key_bits[255 - 32 * j -: 32];
   end

   always_comb begin
      case (cmd.mode)
         MODE_AES192: nk = 4'd6;
         MODE_AES256: nk = 4'd8;
         default:     nk = 4'd4;
      endcase
      nk_last = 3'(nk - 4'd1);
      full_words = {1'b0, nk, 2'b00} + 7'd28;
      if (full_words > MAX_WORDS) begin
         last_idx = IW'(MAX_WORDS - 7'd1);
      end else begin
         last_idx = IW'(full_words - 7'd1);
      end
      in_key = ({{(7 - IW){1'b0}}, idx_ff} < {3'b000, nk});
      back_word = win_ff[nk_last];
      t = win_ff[0];
      if (pos_ff == 3'd0) begin
         t = sub_word({t[23:0], t[31:24]}) ^ {rc_ff, 24'h0};
      end else if (cmd.mode == MODE_AES256 && pos_ff == 3'd4) begin
         t = sub_word(t);
      end
      new_word = in_key ? key_word[idx_ff[2:0]] : (back_word ^ t);
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      rc_in = rc_ff;
      we = 1'b0;
      case (state_ff)
         KX_IDLE: begin
            if (cmd.restart) begin
               state_in = KX_RUN;
               idx_in = '0;
               pos_in = '0;
               rc_in = RCON_FIRST;
            end
         end
         KX_RUN: begin
            if (cmd.restart) begin
               idx_in = '0;
               pos_in = '0;
               rc_in = RCON_FIRST;
            end else begin
               we = 1'b1;
               idx_in = idx_ff + 1'b1;
               pos_in = (pos_ff == nk_last) ? 3'd0 : pos_ff + 3'd1;
               if (!in_key && pos_ff == 3'd0) begin
                  rc_in = xtime(rc_ff);
               end
               if (idx_ff == last_idx) begin
                  state_in = KX_IDLE;
               end
            end
         end
         default: state_in = KX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KX_RUN;
         idx_ff <= '0;
         pos_ff <= '0;
         rc_ff <= RCON_FIRST;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         pos_ff <= pos_in;
         rc_ff <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         round_key_ff[idx_ff] <= new_word;
         win_ff[0] <= new_word;
         for (int k = 1; k < 8; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   assign round_keys = round_key_ff;
   assign status.busy = (state_ff == KX_RUN);

endmodule

### rtl/aes_round.sv
module aes_round
   import aes_pkg::*;
#(
   parameter int ROUND = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl_in,
   input  logic [127:0]  data_in,
   input  logic [3:0]    num_rounds,
   input  logic [127:0]  rk_enc,
   input  logic [127:0]  rk_dec,
   output stage_ctl_type ctl_out,
   output logic [127:0]  data_out
);

   localparam logic [3:0] RND = 4'(ROUND);

   logic          active, last;
   logic [127:0]  enc, dec, result;
   stage_ctl_type ctl_ff;
   logic [127:0]  data_ff;

   always_comb begin
      active = (RND <= num_rounds);
      last = (RND == num_rounds);
      enc = shift_rows(sub_bytes(data_in, 1'b0), 1'b0);
      if (!last) begin
         enc = mix_columns(enc, 1'b0);
      end
      enc = enc ^ rk_enc;
      dec = sub_bytes(shift_rows(data_in, 1'b1), 1'b1) ^ rk_dec;
      if (!last) begin
         dec = mix_columns(dec, 1'b1);
      end
      if (!active) begin
         result = data_in;
      end else begin
         result = ctl_in.func ? dec : enc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff.func <= ctl_in.func;
      data_ff <= result;
   end

   assign ctl_out = ctl_ff;
   assign data_out = data_ff;

endmodule

### rtl/aes_block_cipher.sv
// Pipeline: fifteen stages, key add then one round a stage, end in rsp_valid.
// Throughput: one request per cycle, accepted when start is high and busy low.
// Busy: after reset and after each key register write the key schedule unit writes
// one round-key word a cycle: 44, 52 or 60 words for 128-, 192- or 256-bit keys.
// Reset: synchronous; clears control, key registers, then expands the all-zero key.
// Results: rsp_valid is a one-cycle strobe; the receiver cannot stall.
module aes_block_cipher
   import aes_pkg::*;
#(
   parameter int MAX_KEY_WORDS_STORED = MAX_KEY_WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_out_high,
   output logic [63:0] rsp_out_low,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   localparam int LATENCY = NUM_ROUNDS_MAX + 1;

   // configuration registers
   logic [1:0]  key_length_mode_ff, key_length_mode_in;
   logic [63:0] key_ff [4];
   logic [63:0] key_in [4];
   logic        csr_write;
   logic [2:0]  csr_index;
   logic        csr_hit;

   kx_cmd_type    kx_cmd;
   kx_status_type kx_status;
   logic [31:0]   round_keys [MAX_KEY_WORDS_STORED];

   logic [127:0]  rk_round [NUM_ROUNDS_MAX + 1];
   logic [3:0]    num_rounds;
   logic          accept;

   stage_ctl_type stage_ctl [NUM_ROUNDS_MAX + 1];
   logic [127:0]  stage_data [NUM_ROUNDS_MAX + 1];
   stage_ctl_type stage0_ctl_ff;
   logic [127:0]  stage0_data_ff, stage0_data_in, first_key;

   // APB write: register written on the access cycle
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[5:3];
   assign csr_hit = csr_write && (csr_index <= CSR_KEY_3);

   always_comb begin
      key_length_mode_in = key_length_mode_ff;
      key_in = key_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_KEY_MODE: key_length_mode_in = pwdata[1:0];
            CSR_KEY_0:    key_in[0] = pwdata;
            CSR_KEY_1:    key_in[1] = pwdata;
            CSR_KEY_2:    key_in[2] = pwdata;
            CSR_KEY_3:    key_in[3] = pwdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_mode_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            key_ff[k] <= '0;
         end
      end else begin
         key_length_mode_ff <= key_length_mode_in;
         key_ff <= key_in;
      end
   end

   always_comb begin
      case (csr_index)
         CSR_KEY_MODE: prdata = {62'd0, key_length_mode_ff};
         CSR_KEY_0:    prdata = key_ff[0];
         CSR_KEY_1:    prdata = key_ff[1];
         CSR_KEY_2:    prdata = key_ff[2];
         CSR_KEY_3:    prdata = key_ff[3];
         default:      prdata = '0;
      endcase
   end

   // restart the schedule on every register write; it reads the live registers
   assign kx_cmd.restart = csr_hit;
   assign kx_cmd.mode = key_length_mode_ff;

   aes_key_expand #(
      .MAX_KEY_WORDS_STORED(MAX_KEY_WORDS_STORED)
   ) u_key_expand (
      .clock      (clock),
      .reset      (reset),
      .cmd        (kx_cmd),
      .key_bits   ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .status     (kx_status),
      .round_keys (round_keys)
   );

   // round key r is words 4r..4r+3; words beyond the store read as zero
   for (genvar r = 0; r <= NUM_ROUNDS_MAX; r++) begin : g_rk
      for (genvar c = 0; c < BLOCK_WORDS; c++) begin : g_col
         if (r * BLOCK_WORDS + c < MAX_KEY_WORDS_STORED) begin : g_in
            assign rk_round[r][127 - 32 * c -: 32] = round_keys[r * BLOCK_WORDS + c];
         end else begin : g_out
            assign rk_round[r][127 - 32 * c -: 32] = '0;
         end
      end
   end

   assign num_rounds = rounds_of(key_length_mode_ff);
   assign busy = kx_status.busy;
   assign accept = start && !busy;

   // stage 0: initial key add; decryption starts from the last round key
   always_comb begin
      case (key_length_mode_ff)
         MODE_AES192: first_key = req_func ? rk_round[12] : rk_round[0];
         MODE_AES256: first_key = req_func ? rk_round[14] : rk_round[0];
         default:     first_key = req_func ? rk_round[10] : rk_round[0];
      endcase
      stage0_data_in = {req_block_high, req_block_low} ^ first_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage0_ctl_ff.valid <= 1'b0;
      end else begin
         stage0_ctl_ff.valid <= accept;
      end
   end

   always_ff @(posedge clock) begin
      stage0_ctl_ff.func <= req_func;
      stage0_data_ff <= stage0_data_in;
   end

   assign stage_ctl[0] = stage0_ctl_ff;
   assign stage_data[0] = stage0_data_ff;

   // rounds 1..14; stages past the last round for the key length pass data through
   for (genvar r = 1; r <= NUM_ROUNDS_MAX; r++) begin : g_round
      logic [127:0] dk10, dk12, dk14, rk_dec;
      if (r <= 10) begin : g_d10
         assign dk10 = rk_round[10 - r];
      end else begin : g_n10
         assign dk10 = '0;
      end
      if (r <= 12) begin : g_d12
         assign dk12 = rk_round[12 - r];
      end else begin : g_n12
         assign dk12 = '0;
      end
      assign dk14 = rk_round[NUM_ROUNDS_MAX - r];

      always_comb begin
         case (key_length_mode_ff)
            MODE_AES192: rk_dec = dk12;
            MODE_AES256: rk_dec = dk14;
            default:     rk_dec = dk10;
         endcase
      end

      aes_round #(
         .ROUND(r)
      ) u_round (
         .clock      (clock),
         .reset      (reset),
         .ctl_in     (stage_ctl[r-1]),
         .data_in    (stage_data[r-1]),
         .num_rounds (num_rounds),
         .rk_enc     (rk_round[r]),
         .rk_dec     (rk_dec),
         .ctl_out    (stage_ctl[r]),
         .data_out   (stage_data[r])
      );
   end

   // drive results straight from the last stage register
   assign rsp_valid = stage_ctl[NUM_ROUNDS_MAX].valid;
   assign rsp_out_high = stage_data[NUM_ROUNDS_MAX][127:64];
   assign rsp_out_low = stage_data[NUM_ROUNDS_MAX][63:0];

`ifndef SYNTH
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> stage0_ctl_ff.valid)
      else $error("accepted request did not enter the pipeline");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without a request fifteen cycles earlier");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> busy)
      else $error("key write did not start the key schedule");
`endif

endmodule

### bench/aes_block_cipher_tb.sv
`timescale 1ns / 1ps

module aes_block_cipher_tb;
   import aes_pkg::*;

   localparam int CLK_HALF = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PIPE_DRAIN = 24;    // a bit more than the 15-stage pipeline
   localparam int RAND_PER_KEY = 200;

   // one request of the directed part; expected result typed in only where known by heart
   typedef struct {
      logic         func;
      logic [63:0]  blk_hi;
      logic [63:0]  blk_lo;
      bit           typed;
      logic [127:0] result;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [63:0] req_block_high;
   logic [63:0] req_block_low;
   logic        rsp_valid;
   logic [63:0] rsp_out_high;
   logic [63:0] rsp_out_low;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [5:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   // predictor state: key registers, round keys and substitution tables
   logic [1:0]   key_mode;
   logic [63:0]  key_reg [4];
   logic [31:0]  round_keys [60];
   logic [7:0]   fwd_sub [256];
   logic [7:0]   inv_sub [256];
   logic [127:0] pending_blocks [$];
   int           fail_count;
   int           cycle_count;

   aes_block_cipher u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_block_high (req_block_high),
      .req_block_low  (req_block_low),
      .rsp_valid      (rsp_valid),
      .rsp_out_high   (rsp_out_high),
      .rsp_out_low    (rsp_out_low),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // GF(2^8) arithmetic over x^8 + x^4 + x^3 + x + 1
   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = gf_double(a);
      end
      return acc;
   endfunction

   // build S-box from the multiplicative inverse plus the affine map
   task automatic build_sub_tables();
      logic [7:0] inv;
      logic [7:0] v;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
         if (x == 0) inv = 8'h00;
         v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         fwd_sub[x] = v;
      end
      for (int x = 0; x < 256; x++) inv_sub[fwd_sub[x]] = 8'(x);
   endtask

   function automatic int key_word_count();
      if (key_mode == MODE_AES192) return 6;
      if (key_mode == MODE_AES256) return 8;
      return 4;   // unused mode code acts as a 128-bit key
   endfunction

   function automatic logic [31:0] sub_key_word(input logic [31:0] w);
      return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
   endfunction

   task automatic expand_schedule();
      int         nk;
      int         total;
      logic [7:0] rcon;
      logic [31:0] t;
      nk = key_word_count();
      total = 4 * (nk + 7);
      if (total > 60) total = 60;
      rcon = 8'h01;
      for (int i = 0; i < nk; i++) begin
         round_keys[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
      end
      for (int i = nk; i < total; i++) begin
         t = round_keys[i - 1];
         if (i % nk == 0) begin
            t = sub_key_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
            rcon = gf_double(rcon);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub_key_word(t);
         end
         round_keys[i] = round_keys[i - nk] ^ t;
      end
   endtask

   // state bytes st[c*4+r]: column c, row r, filled column by column
   function automatic void xor_round_key(inout logic [7:0] st [16], input int rnd);
      logic [31:0] w;
      for (int c = 0; c < 4; c++) begin
         w = round_keys[rnd * 4 + c];
         for (int r = 0; r < 4; r++) st[c * 4 + r] ^= w[31 - 8 * r -: 8];
      end
   endfunction

   function automatic void substitute(inout logic [7:0] st [16], input bit inverse);
      for (int i = 0; i < 16; i++) st[i] = inverse ? inv_sub[st[i]] : fwd_sub[st[i]];
   endfunction

   function automatic void rotate_rows(inout logic [7:0] st [16], input bit inverse);
      logic [7:0] t [16];
      t = st;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inverse) st[((c + r) % 4) * 4 + r] = t[c * 4 + r];
            else st[c * 4 + r] = t[((c + r) % 4) * 4 + r];
         end
      end
   endfunction

   function automatic void mix_state(inout logic [7:0] st [16], input bit inverse);
      logic [7:0] coef [4];
      logic [7:0] col [4];
      logic [7:0] acc;
      if (inverse) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) col[k] = st[c * 4 + k];
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) acc ^= gf_mul(coef[(k + 4 - r) % 4], col[k]);
            st[c * 4 + r] = acc;
         end
      end
   endfunction

   function automatic logic [127:0] cipher_block(input logic func, input logic [63:0] hi,
                                                 input logic [63:0] lo);
      logic [7:0]   st [16];
      logic [127:0] blk;
      int           nr;
      nr = key_word_count() + 6;
      blk = {hi, lo};
      for (int i = 0; i < 16; i++) st[i] = blk[127 - 8 * i -: 8];
      if (!func) begin
         xor_round_key(st, 0);
         for (int rnd = 1; rnd < nr; rnd++) begin
            substitute(st, 0);
            rotate_rows(st, 0);
            mix_state(st, 0);
            xor_round_key(st, rnd);
         end
         substitute(st, 0);
         rotate_rows(st, 0);
         xor_round_key(st, nr);
      end else begin
         xor_round_key(st, nr);
         for (int rnd = nr - 1; rnd > 0; rnd--) begin
            rotate_rows(st, 1);
            substitute(st, 1);
            xor_round_key(st, rnd);
            mix_state(st, 1);
         end
         rotate_rows(st, 1);
         substitute(st, 1);
         xor_round_key(st, 0);
      end
      for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = st[i];
      return blk;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // register write: setup cycle then access cycle, then wait out the key expansion
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = 6'(idx) << 3;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      // update the predictor; out-of-range indexes are dropped
      if (idx == CSR_KEY_MODE) key_mode = value[1:0];
      else if (idx <= CSR_KEY_3) key_reg[idx - 1] = value;
      expand_schedule();
      // let busy rise, then hold until the schedule is rebuilt
      @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   // drive one request and hold it until the block takes it
   task automatic send_request(input logic func, input logic [63:0] hi, input logic [63:0] lo,
                               input bit typed = 0, input logic [127:0] result = '0);
      @(negedge clock);
      start = 1'b1;
      req_func = func;
      req_block_high = hi;
      req_block_low = lo;
      do @(posedge clock); while (busy);
      pending_blocks.push_back(typed ? result : cipher_block(func, hi, lo));
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold the sender until every pending request has come back, then drain the pipe
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_blocks.size() != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic load_key(input logic [1:0] mode, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
      wait_drained();
      write_reg(CSR_KEY_MODE, 64'(mode));
      write_reg(CSR_KEY_0, k0);
      write_reg(CSR_KEY_1, k1);
      write_reg(CSR_KEY_2, k2);
      write_reg(CSR_KEY_3, k3);
   endtask

   // random traffic in bursts with random gaps; some bursts run back to back
   task automatic random_traffic(input int count);
      int   burst;
      int   sent;
      logic [63:0] hi;
      logic [63:0] lo;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int b = 0; b < burst && sent < count; b++) begin
            hi = rand64();
            lo = rand64();
            case ($urandom_range(0, 9))
               0: hi = '0;
               1: lo = '1;
               2: begin
                  hi = '1;
                  lo = '0;
               end
               default: ;
            endcase
            send_request(1'($urandom), hi, lo);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
      end
   endtask

   // compare each strobed result against the oldest pending block
   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset && rsp_valid) begin
         if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected result %h %h", $time, rsp_out_high, rsp_out_low);
            fail_count++;
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_out_high !== want[127:64]) begin
               $display("%0t: out_high expected %h actual %h", $time, want[127:64],
                        rsp_out_high);
               fail_count++;
            end
            if (rsp_out_low !== want[63:0]) begin
               $display("%0t: out_low expected %h actual %h", $time, want[63:0], rsp_out_low);
               fail_count++;
            end
         end
      end
   end

   // watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      directed_row_type rows [$];
      fail_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_func = 1'b0;
      req_block_high = '0;
      req_block_low = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      key_mode = '0;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      build_sub_tables();
      expand_schedule();

      repeat (4) @(negedge clock);
      reset = 1'b0;
      // hold off until the reset-time key expansion is done
      @(negedge clock);
      while (busy) @(negedge clock);

      // directed part under the all-zero 128-bit key left by reset
      rows = '{
         '{1'b0, 64'h0, 64'h0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
         '{1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 128'h0},
         '{1'b1, 64'h0, 64'h0, 0, 128'h0},
         '{1'b0, '1, '1, 0, 128'h0},
         '{1'b1, '1, '1, 0, 128'h0},
         '{1'b0, 64'h8000000000000000, 64'h0, 0, 128'h0},
         '{1'b1, 64'h0, 64'h0000000000000001, 0, 128'h0},
         '{1'b0, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 0, 128'h0},
         '{1'b1, 64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5, 0, 128'h0},
         '{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 0, 128'h0}
      };
      foreach (rows[i]) begin
         send_request(rows[i].func, rows[i].blk_hi, rows[i].blk_lo, rows[i].typed,
                      rows[i].result);
      end

      // directed key settings: a 128-bit key, the unused mode code,
      // and a write to an address past the last register (ignored)
      load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
      send_request(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                   128'h69c4e0d86a7b0430d8cdb78070b4c55a);
      send_request(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
                   128'h00112233445566778899aabbccddeeff);
      load_key(2'd3, rand64(), rand64(), rand64(), rand64());
      send_request(1'b0, 64'h0, 64'h0);
      send_request(1'b1, '1, '1);
      wait_drained();
      write_reg(3'd5, rand64());
      send_request(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);

      // random part: several key settings, extremes among them
      load_key(2'd0, rand64(), rand64(), rand64(), rand64());
      random_traffic(RAND_PER_KEY);
      load_key(2'd1, '0, '0, '0, '1);
      random_traffic(RAND_PER_KEY);
      load_key(2'd2, '1, '1, '1, '1);
      random_traffic(RAND_PER_KEY);
      load_key(2'd1, rand64(), rand64(), rand64(), rand64());
      random_traffic(RAND_PER_KEY);
      load_key(2'd2, rand64(), rand64(), rand64(), rand64());
      random_traffic(RAND_PER_KEY);
      load_key(2'd3, rand64(), rand64(), rand64(), rand64());
      random_traffic(RAND_PER_KEY);
      load_key(2'd2, '0, '0, '0, '0);
      random_traffic(RAND_PER_KEY);
      load_key(2'd0, rand64(), rand64(), '0, '0);
      random_traffic(RAND_PER_KEY);

      // drain and report
      wait_drained();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // leftover expectations are caught here: wait_drained never returns with any pending,
   // so a missing result ends the run through the watchdog
endmodule

### filelist.f
rtl/aes_pkg.sv
rtl/aes_key_expand.sv
rtl/aes_round.sv
rtl/aes_block_cipher.sv
bench/aes_block_cipher_tb.sv
